// ===== sv/triangle_face_normal_unit_assert.svh =====
// Assertion macros for the triangle face normal unit.
// Each macro names clk and arst_n of the module that uses it.
`ifndef TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TFN_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TFN_ASSERT_DELAY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);
`else
`define TFN_ASSERT_IMPL(lbl, ante, cons, msg)
`define TFN_ASSERT_DELAY(lbl, ante, n, cons, msg)
`endif
`endif

// ===== sv/tfn_pkg.sv =====
`default_nettype none
package tfn_pkg;
	// Field widths.
	localparam int COORD_BITS  = 24;
	localparam int NORMAL_BITS = 16;

	// Derived widths: edges, products, cross terms, normalised magnitudes.
	localparam int EW  = COORD_BITS + 1;
	localparam int PW  = 2 * EW;
	localparam int XW  = PW + 1;
	localparam int MW  = XW;
	localparam int MB  = 31;
	localparam int LW  = MW + MB;
	localparam int LZW = $clog2(LW + 1);
	localparam int SQW = 2 * MB;
	localparam int SW  = SQW + 2;
	localparam int RW  = SW / 2;
	localparam int QW  = NORMAL_BITS;
	localparam int DW  = MB + QW + 1;

	// Register stages of each part, and the whole latency.
	localparam int CROSS_STAGES = 3;
	localparam int NORM_STAGES  = 5;
	localparam int LATENCY      = CROSS_STAGES + NORM_STAGES + RW + QW + 1;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} vert_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [XW-1:0] z;
	} cross_t;

	// Data that rides alongside the root and divide stages.
	typedef struct packed {
		logic [2:0][MB-1:0] m;
		logic [2:0]         neg;
		logic               degen;
	} side_t;
endpackage
`default_nettype wire

// ===== sv/tfn_cross.sv =====
`default_nettype none
module tfn_cross (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire tfn_pkg::vert_t v0,
	input  wire tfn_pkg::vert_t v1,
	input  wire tfn_pkg::vert_t v2,
	output logic                out_valid,
	output tfn_pkg::cross_t     xprod
);
	import tfn_pkg::*;

	logic                 valid_s1, valid_s2, valid_s3;
	logic signed [EW-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	cross_t               cross_s3;

	// Valid bits travel with the words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Edges, then the six products, then the cross components.
	always_ff @(posedge clk) begin
		e1x_s1 <= EW'(v1.x) - EW'(v0.x);
		e1y_s1 <= EW'(v1.y) - EW'(v0.y);
		e1z_s1 <= EW'(v1.z) - EW'(v0.z);
		e2x_s1 <= EW'(v2.x) - EW'(v0.x);
		e2y_s1 <= EW'(v2.y) - EW'(v0.y);
		e2z_s1 <= EW'(v2.z) - EW'(v0.z);
		pa_s2  <= PW'(e1y_s1) * PW'(e2z_s1);
		pb_s2  <= PW'(e1z_s1) * PW'(e2y_s1);
		pc_s2  <= PW'(e1z_s1) * PW'(e2x_s1);
		pd_s2  <= PW'(e1x_s1) * PW'(e2z_s1);
		pe_s2  <= PW'(e1x_s1) * PW'(e2y_s1);
		pf_s2  <= PW'(e1y_s1) * PW'(e2x_s1);
		cross_s3.x <= XW'(pa_s2) - XW'(pb_s2);
		cross_s3.y <= XW'(pc_s2) - XW'(pd_s2);
		cross_s3.z <= XW'(pe_s2) - XW'(pf_s2);
	end

	assign out_valid = valid_s3;
	assign xprod     = cross_s3;
endmodule
`default_nettype wire

// ===== sv/tfn_norm.sv =====
`default_nettype none
module tfn_norm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire tfn_pkg::cross_t xprod,
	output logic                 out_valid,
	output logic [tfn_pkg::SW-1:0] sum,
	output tfn_pkg::side_t       side
);
	import tfn_pkg::*;

	logic [4:0]           valid_q;
	logic [2:0][MW-1:0]   mag_s4, mag_s5;
	logic [2:0]           neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [MW-1:0]        or_s4;
	logic [LZW-1:0]       lz_s5;
	logic                 degen_s5, degen_s6, degen_s7, degen_s8;
	logic [2:0][MB-1:0]   m_s6, m_s7, m_s8;
	logic [2:0][SQW-1:0]  sq_s7;
	logic [SW-1:0]        sum_s8;
	logic [LZW-1:0]       lz_c;
	logic [2:0][MB-1:0]   m_c;
	logic [LW-1:0]        wide_c;
	logic [XW-1:0]        comp_c [3];

	assign comp_c[0] = xprod.x;
	assign comp_c[1] = xprod.y;
	assign comp_c[2] = xprod.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[3:0], in_valid};
		end
	end

	// Leading zero count of the OR of the magnitudes, over the widened word.
	always_comb begin
		lz_c = LZW'(LW);
		for (int i = 0; i < MW; i++) begin
			if (or_s4[i]) begin
				lz_c = LZW'(LW - 1 - i);
			end
		end
	end

	// Shift so that the largest magnitude fills the top bit; keep the top bits.
	always_comb begin
		wide_c = '0;
		for (int i = 0; i < 3; i++) begin
			wide_c = LW'(mag_s5[i]) << lz_s5;
			m_c[i] = wide_c[LW-1 -: MB];
		end
	end

	always_ff @(posedge clk) begin
		// Magnitudes and signs.
		for (int i = 0; i < 3; i++) begin
			mag_s4[i] <= comp_c[i][XW-1] ? MW'(-comp_c[i]) : MW'(comp_c[i]);
			neg_s4[i] <= comp_c[i][XW-1];
		end
		or_s4    <= MW'(xprod.x[XW-1] ? -xprod.x : xprod.x)
			| MW'(xprod.y[XW-1] ? -xprod.y : xprod.y)
			| MW'(xprod.z[XW-1] ? -xprod.z : xprod.z);
		mag_s5   <= mag_s4;
		neg_s5   <= neg_s4;
		lz_s5    <= lz_c;
		degen_s5 <= (or_s4 == '0);
		m_s6     <= m_c;
		neg_s6   <= neg_s5;
		degen_s6 <= degen_s5;
		// Squares, then their sum.
		for (int i = 0; i < 3; i++) begin
			sq_s7[i] <= SQW'(m_s6[i]) * SQW'(m_s6[i]);
		end
		m_s7     <= m_s6;
		neg_s7   <= neg_s6;
		degen_s7 <= degen_s6;
		sum_s8   <= SW'(sq_s7[0]) + SW'(sq_s7[1]) + SW'(sq_s7[2]);
		m_s8     <= m_s7;
		neg_s8   <= neg_s7;
		degen_s8 <= degen_s7;
	end

	assign out_valid  = valid_q[4];
	assign sum        = sum_s8;
	assign side.m     = m_s8;
	assign side.neg   = neg_s8;
	assign side.degen = degen_s8;
endmodule
`default_nettype wire

// ===== sv/tfn_isqrt.sv =====
`default_nettype none
module tfn_isqrt (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [tfn_pkg::SW-1:0] sum,
	input  wire tfn_pkg::side_t       side_in,
	output logic                      out_valid,
	output logic [tfn_pkg::RW-1:0]    root,
	output tfn_pkg::side_t            side_out
);
	import tfn_pkg::*;

	// Entry 0 is the stage input; entry k+1 is the register after step k.
	logic          valid_s [RW+1];
	logic [RW:0]   rem_s   [RW+1];
	logic [RW-1:0] root_s  [RW+1];
	logic [SW-1:0] rad_s   [RW+1];
	side_t         side_s  [RW+1];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign rad_s[0]   = sum;
	assign side_s[0]  = side_in;

	// One root bit per stage: bring down two radicand bits and try the next bit.
	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW+2:0] rem_c, trial_c;
		logic          fit_c;

		assign rem_c   = {rem_s[k], rad_s[k][SW-1 -: 2]};
		assign trial_c = {1'b0, root_s[k], 2'b01};
		assign fit_c   = (rem_c >= trial_c);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= fit_c ? (RW+1)'(rem_c - trial_c) : (RW+1)'(rem_c);
			root_s[k+1] <= {root_s[k][RW-2:0], fit_c};
			rad_s[k+1]  <= rad_s[k] << 2;
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[RW];
	assign root      = root_s[RW];
	assign side_out  = side_s[RW];
endmodule
`default_nettype wire

// ===== sv/tfn_div.sv =====
`default_nettype none
module tfn_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [tfn_pkg::RW-1:0] root,
	input  wire tfn_pkg::side_t       side_in,
	output logic                      out_valid,
	output logic [2:0][tfn_pkg::QW-1:0] quot,
	output tfn_pkg::side_t            side_out
);
	import tfn_pkg::*;

	logic               valid_s [QW+1];
	logic [2:0][DW-1:0] rem_s   [QW+1];
	logic [2:0][QW-1:0] quot_s  [QW+1];
	logic [RW-1:0]      div_s   [QW+1];
	side_t              side_s  [QW+1];

	// Rounded numerator: magnitude scaled to the output format plus half the root.
	for (genvar i = 0; i < 3; i++) begin : g_num
		assign rem_s[0][i] = (DW'(side_in.m[i]) << (QW - 1)) + DW'(root >> 1);
	end
	assign valid_s[0] = in_valid;
	assign quot_s[0]  = '0;
	assign div_s[0]   = root;
	assign side_s[0]  = side_in;

	// One quotient bit per stage, restoring, for all three components.
	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] dsh_c;

		assign dsh_c = DW'(div_s[k]) << (QW - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_s[k][i] >= dsh_c) begin
					rem_s[k+1][i]  <= rem_s[k][i] - dsh_c;
					quot_s[k+1][i] <= {quot_s[k][i][QW-2:0], 1'b1};
				end else begin
					rem_s[k+1][i]  <= rem_s[k][i];
					quot_s[k+1][i] <= {quot_s[k][i][QW-2:0], 1'b0};
				end
			end
			div_s[k+1]  <= div_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[QW];
	assign quot      = quot_s[QW];
	assign side_out  = side_s[QW];
endmodule
`default_nettype wire

// ===== sv/triangle_face_normal_unit.sv =====
// Channel   Handshake              Words
// input     start, busy            v0_*, v1_*, v2_* (24-bit signed)
// result    done (one-cycle pulse) normal_x/y/z (Q1.15), degenerate
//
// One triangle may be started in every cycle; busy is always low.
// After its start, each result passes through 3 cross stages, 5 normalising stages,
// 32 root stages, 16 divide stages and the output register.
// Reset clears only the valid bits; the receiver cannot hold results off.
`default_nettype none
`include "triangle_face_normal_unit_assert.svh"
module triangle_face_normal_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v0_x,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v0_y,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v0_z,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v1_x,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v1_y,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v1_z,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v2_x,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v2_y,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] v2_z,
	output logic                                      done,
	output logic signed [tfn_pkg::NORMAL_BITS-1:0]    normal_x,
	output logic signed [tfn_pkg::NORMAL_BITS-1:0]    normal_y,
	output logic signed [tfn_pkg::NORMAL_BITS-1:0]    normal_z,
	output logic                                      degenerate
);
	import tfn_pkg::*;

	localparam logic [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};

	vert_t              v0, v1, v2;
	logic               cr_valid, nm_valid, sq_valid, dv_valid;
	cross_t             cr_word;
	logic [SW-1:0]      nm_sum;
	side_t              nm_side, sq_side, dv_side;
	logic [RW-1:0]      sq_root;
	logic [2:0][QW-1:0] dv_quot;
	logic [2:0][QW-1:0] res_c;
	logic               done_q;
	logic [2:0][QW-1:0] normal_q;
	logic               degen_q;

	assign busy = 1'b0;
	assign v0 = '{x: v0_x, y: v0_y, z: v0_z};
	assign v1 = '{x: v1_x, y: v1_y, z: v1_z};
	assign v2 = '{x: v2_x, y: v2_y, z: v2_z};

	tfn_cross u_cross (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.v0(v0), .v1(v1), .v2(v2), .out_valid(cr_valid), .xprod(cr_word)
	);

	tfn_norm u_norm (
		.clk(clk), .arst_n(arst_n), .in_valid(cr_valid), .xprod(cr_word),
		.out_valid(nm_valid), .sum(nm_sum), .side(nm_side)
	);

	tfn_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(nm_valid), .sum(nm_sum),
		.side_in(nm_side), .out_valid(sq_valid), .root(sq_root), .side_out(sq_side)
	);

	tfn_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_valid), .root(sq_root),
		.side_in(sq_side), .out_valid(dv_valid), .quot(dv_quot), .side_out(dv_side)
	);

	// Saturate, apply the sign, and force zero for a degenerate triangle.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [QW-1:0] q;
			q = dv_quot[i][QW-1] ? QMAX : dv_quot[i];
			if (dv_side.degen) begin
				res_c[i] = '0;
			end else if (dv_side.neg[i]) begin
				res_c[i] = -q;
			end else begin
				res_c[i] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		normal_q <= res_c;
		degen_q  <= dv_side.degen;
	end

	assign done       = done_q;
	assign normal_x   = normal_q[0];
	assign normal_y   = normal_q[1];
	assign normal_z   = normal_q[2];
	assign degenerate = degen_q;

	`TFN_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done, "result word missing")
	`TFN_ASSERT_IMPL(a_degen_zero, done && degenerate,
		normal_x == '0 && normal_y == '0 && normal_z == '0, "degenerate normal not zero")
	`TFN_ASSERT_IMPL(a_nonzero, done && !degenerate,
		normal_x != '0 || normal_y != '0 || normal_z != '0, "zero normal without flag")
	`TFN_ASSERT_IMPL(a_sat, done,
		normal_x != {1'b1, {(QW-1){1'b0}}} && normal_y != {1'b1, {(QW-1){1'b0}}}
		&& normal_z != {1'b1, {(QW-1){1'b0}}}, "normal outside saturation range")
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Expected normals for accepted triangles, held in start order and compared
// with each done pulse.
class normal_scoreboard;
	typedef struct {
		logic signed [15:0] nx, ny, nz;
		logic               degen;
	} normal_word_t;

	normal_word_t pending[$];
	int unsigned  mismatches;

	// Magnitude of the shifted cross component, as the block normalises it.
	static function automatic logic [63:0] shift_mag(logic [127:0] mag, int sh);
		if (sh > 0)
			return 64'(mag >> sh);
		return 64'(mag << (-sh));
	endfunction

	static function automatic logic [63:0] int_sqrt(logic [63:0] s);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Work out the unit normal of one triangle and queue it.
	function void note_triangle(logic signed [23:0] v[9]);
		logic signed [127:0] e[6], c[3];
		logic [127:0]        cm[3];
		logic [63:0]         m[3], sum, r, q;
		normal_word_t        w;
		int                  len, sh, l;
		for (int i = 0; i < 3; i++) begin
			e[i]     = 128'(v[3 + i]) - 128'(v[i]);
			e[3 + i] = 128'(v[6 + i]) - 128'(v[i]);
		end
		c[0] = e[1] * e[5] - e[2] * e[4];
		c[1] = e[2] * e[3] - e[0] * e[5];
		c[2] = e[0] * e[4] - e[1] * e[3];
		len = 0;
		for (int i = 0; i < 3; i++) begin
			cm[i] = c[i] < 0 ? -c[i] : c[i];
			l = 0;
			for (int b = 0; b < 128; b++)
				if (cm[i][b])
					l = b + 1;
			if (l > len)
				len = l;
		end
		w.degen = (len == 0);
		w.nx = 0;
		w.ny = 0;
		w.nz = 0;
		if (len != 0) begin
			sh = len - 31;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				m[i] = shift_mag(cm[i], sh);
				sum += m[i] * m[i];
			end
			r = int_sqrt(sum);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << 15) + (r >> 1)) / r;
				if (q > 32767)
					q = 32767;
				if (c[i] < 0)
					q = -q;
				case (i)
					0: w.nx = q[15:0];
					1: w.ny = q[15:0];
					default: w.nz = q[15:0];
				endcase
			end
		end
		pending.push_back(w);
	endfunction

	// Compare one result word with the oldest expectation.
	function void check_normal(logic signed [15:0] nx, ny, nz, logic degen);
		normal_word_t w;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %0d %0d %0d %0b", nx, ny, nz, degen);
			return;
		end
		w = pending.pop_front();
		if (nx !== w.nx || ny !== w.ny || nz !== w.nz || degen !== w.degen) begin
			mismatches++;
			if (mismatches <= 10)
				$display("normal mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
					w.nx, w.ny, w.nz, w.degen, nx, ny, nz, degen);
		end
	endfunction
endclass

module tb;
	localparam int CYCLE_LIMIT = 200000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy, done, degenerate;
	logic signed [23:0] vin[9];
	logic signed [15:0] normal_x, normal_y, normal_z;

	normal_scoreboard   sb = new();
	int unsigned        cycles = 0;

	initial
		for (int i = 0; i < 9; i++)
			vin[i] = '0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	triangle_face_normal_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.v0_x(vin[0]), .v0_y(vin[1]), .v0_z(vin[2]),
		.v1_x(vin[3]), .v1_y(vin[4]), .v1_z(vin[5]),
		.v2_x(vin[6]), .v2_y(vin[7]), .v2_z(vin[8]),
		.done(done), .normal_x(normal_x), .normal_y(normal_y),
		.normal_z(normal_z), .degenerate(degenerate)
	);

	// Accepted starts feed the scoreboard; done pulses are checked.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && start && !busy)
			sb.note_triangle(vin);
		if (arst_n && done)
			sb.check_normal(normal_x, normal_y, normal_z, degenerate);
	end

	always @(posedge clk)
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end

	// Present one triangle word and hold it until accepted.
	task automatic send_triangle(logic signed [23:0] t[9]);
		for (int i = 0; i < 9; i++)
			vin[i] <= t[i];
		start <= 1;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a random gap, mostly short.
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 2) == 0)
			n = 0;
		if (n > 0) begin
			start <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic signed [23:0] rnd_coord(int mode);
		case (mode)
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 64)) - 32);
			default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
		endcase
	endfunction

	initial begin
		logic signed [23:0] t[9];
		int                 mode;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: degenerate, axis-aligned, extremes.
		t = '{default: 0};
		send_triangle(t);
		t = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
		send_triangle(t);
		t = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
		send_triangle(t);
		t = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
		send_triangle(t);
		t = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
		send_triangle(t);
		t = '{24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000,
			24'h800000, 24'h7FFFFF, 24'h800000};
		send_triangle(t);
		t = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
			24'h800000, 24'h800000, 24'h7FFFFF};
		send_triangle(t);
		t = '{24'h800000, 24'h7FFFFF, 0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
			24'h7FFFFF, 24'h7FFFFF, 24'h800000};
		send_triangle(t);
		t = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
		send_triangle(t);
		t = '{5, 5, 5, 5, 5, 5, 9, 9, 9};
		send_triangle(t);

		// Random triangles with a mix of coordinate ranges.
		for (int n = 0; n < 1650; n++) begin
			mode = $urandom_range(0, 9);
			for (int i = 0; i < 9; i++)
				t[i] = rnd_coord(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
			if ($urandom_range(0, 19) == 0)
				for (int i = 0; i < 3; i++)
					t[6 + i] = t[3 + i];
			send_triangle(t);
			if (n == 800) begin
				start <= 0;
				while (sb.pending.size() != 0)
					@(posedge clk);
			end else begin
				idle_gap();
			end
		end
		start <= 0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (70) @(posedge clk);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

`default_nettype wire
